/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define AABBX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define AABBX_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define AABBX_ASSERT(lbl, clk, rst, prop)
`define AABBX_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* rtl/core/aabbx_pkg.sv */
// ----------------------------------------------------------------------------
// aabbx_pkg
// Types, constants and helpers for the bounding box transform core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabbx_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SUM_WIDTH   = 64;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int AXES        = 3;
   localparam int ROWS        = 3;
   localparam int TERMS       = 4;
   localparam int CORNERS     = 8;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type COORD_ONE = coord_type'(1 << FRAC_BITS);

   typedef enum logic [2:0] {
      OP_POINT = 3'd0,
      OP_BOX   = 3'd1,
      OP_ROW0  = 3'd2,
      OP_ROW1  = 3'd3,
      OP_ROW2  = 3'd4
   } op_type;

   // per-transaction control carried down the pipeline
   typedef struct packed {
      logic valid;
      logic last;
      logic contrib;
      logic point;
   } ctl_type;

   function automatic coord_type sat_coord(input sum_type s);
      sum_type sh;
      sh = s >>> FRAC_BITS;
      if (sh > sum_type'(COORD_MAX)) begin
         return COORD_MAX;
      end else if (sh < sum_type'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return coord_type'(sh);
   endfunction

   function automatic coord_type min_coord(input coord_type a, input coord_type b);
      return (b < a) ? b : a;
   endfunction

   function automatic coord_type max_coord(input coord_type a, input coord_type b);
      return (b > a) ? b : a;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/aabb_transform_accumulate_core.sv */
// ----------------------------------------------------------------------------
// aabb_transform_accumulate_core
// Running bounding box with a 3x4 affine transform on box inputs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | opcode, a_x..a_z, b_x..b_z, last
//  rsp     | out       | rsp_valid/rsp_stall  | out_min/max x..z, box_valid
//
//  One transaction per cycle, sustained while req_stall is low. A request
//  passes the input register, then products, row sums, saturate and corner
//  min/max, then the merge into the result register that drives rsp_valid.
//  The depth is set by the 18 parallel 32x32 multipliers and the corner tree.
//  Reset: identity matrix, empty box, no clearing pass.
//  req_stall rises only while a last transaction reaches the accumulator and
//  the result register still holds a result that is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aabb_transform_accumulate_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_opcode,
   input  wire aabbx_pkg::coord_type req_a_x,
   input  wire aabbx_pkg::coord_type req_a_y,
   input  wire aabbx_pkg::coord_type req_a_z,
   input  wire aabbx_pkg::coord_type req_b_x,
   input  wire aabbx_pkg::coord_type req_b_y,
   input  wire aabbx_pkg::coord_type req_b_z,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output aabbx_pkg::coord_type      rsp_out_min_x,
   output aabbx_pkg::coord_type      rsp_out_min_y,
   output aabbx_pkg::coord_type      rsp_out_min_z,
   output aabbx_pkg::coord_type      rsp_out_max_x,
   output aabbx_pkg::coord_type      rsp_out_max_y,
   output aabbx_pkg::coord_type      rsp_out_max_z,
   output logic                      rsp_box_valid
);

   localparam int AX = aabbx_pkg::AXES;

   logic                 adv;
   logic                 commit;
   logic                 last_commit;
   logic                 mat_wr;
   logic [1:0]           mat_row;
   logic                 s1_valid_ff;
   logic                 s1_last_ff;
   logic [2:0]           s1_op_ff;
   aabbx_pkg::coord_type s1_a_ff [AX];
   aabbx_pkg::coord_type s1_b_ff [AX];
   aabbx_pkg::ctl_type   s1_ctl;
   aabbx_pkg::coord_type mat_ff [aabbx_pkg::ROWS][aabbx_pkg::TERMS];
   aabbx_pkg::ctl_type   s5_ctl;
   aabbx_pkg::coord_type s5_lo [AX];
   aabbx_pkg::coord_type s5_hi [AX];
   aabbx_pkg::coord_type acc_min_ff [AX];
   aabbx_pkg::coord_type acc_max_ff [AX];
   aabbx_pkg::coord_type mrg_min [AX];
   aabbx_pkg::coord_type mrg_max [AX];
   logic                 mrg_ok;
   logic                 rsp_valid_ff, rsp_valid_in;
   aabbx_pkg::coord_type rsp_min_ff [AX];
   aabbx_pkg::coord_type rsp_max_ff [AX];
   logic                 rsp_ok_ff;
   logic                 rsp_ordered;

   assign adv         = !(s5_ctl.valid && s5_ctl.last && rsp_valid_ff && rsp_stall);
   assign req_stall   = !adv;
   assign commit      = adv && s5_ctl.valid;
   assign last_commit = commit && s5_ctl.last;

   // matrix rows load at acceptance so that the next box sees them
   assign mat_wr  = req_valid && adv && (req_opcode == aabbx_pkg::OP_ROW0 ||
                    req_opcode == aabbx_pkg::OP_ROW1 || req_opcode == aabbx_pkg::OP_ROW2);
   assign mat_row = 2'(req_opcode - 3'(aabbx_pkg::OP_ROW0));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < aabbx_pkg::ROWS; r++) begin
            for (int t = 0; t < aabbx_pkg::TERMS; t++) begin
               mat_ff[r][t] <= (r == t) ? aabbx_pkg::COORD_ONE : '0;
            end
         end
      end else if (mat_wr) begin
         mat_ff[mat_row][0] <= req_a_x;
         mat_ff[mat_row][1] <= req_a_y;
         mat_ff[mat_row][2] <= req_a_z;
         mat_ff[mat_row][3] <= req_b_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff <= req_last;
         s1_op_ff   <= req_opcode;
         s1_a_ff[0] <= req_a_x;
         s1_a_ff[1] <= req_a_y;
         s1_a_ff[2] <= req_a_z;
         s1_b_ff[0] <= req_b_x;
         s1_b_ff[1] <= req_b_y;
         s1_b_ff[2] <= req_b_z;
      end
   end

   // boxes with min above max on any axis are dropped
   always_comb begin
      s1_ctl.valid = s1_valid_ff;
      s1_ctl.last  = s1_last_ff;
      s1_ctl.point = (s1_op_ff == aabbx_pkg::OP_POINT);
      case (s1_op_ff)
         aabbx_pkg::OP_POINT: s1_ctl.contrib = 1'b1;
         aabbx_pkg::OP_BOX:   s1_ctl.contrib = (s1_a_ff[0] <= s1_b_ff[0]) &&
                                               (s1_a_ff[1] <= s1_b_ff[1]) &&
                                               (s1_a_ff[2] <= s1_b_ff[2]);
         default:             s1_ctl.contrib = 1'b0;
      endcase
   end

   aabbx_map u_map (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (s1_ctl),
      .in_lo   (s1_a_ff),
      .in_hi   (s1_b_ff),
      .mat     (mat_ff),
      .out_ctl (s5_ctl),
      .out_lo  (s5_lo),
      .out_hi  (s5_hi)
   );

   always_comb begin
      mrg_ok = 1'b1;
      for (int i = 0; i < AX; i++) begin
         if (s5_ctl.contrib) begin
            mrg_min[i] = aabbx_pkg::min_coord(acc_min_ff[i], s5_lo[i]);
            mrg_max[i] = aabbx_pkg::max_coord(acc_max_ff[i], s5_hi[i]);
         end else begin
            mrg_min[i] = acc_min_ff[i];
            mrg_max[i] = acc_max_ff[i];
         end
         if (mrg_min[i] > mrg_max[i]) begin
            mrg_ok = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AX; i++) begin
            acc_min_ff[i] <= aabbx_pkg::COORD_MAX;
            acc_max_ff[i] <= aabbx_pkg::COORD_MIN;
         end
      end else if (commit) begin
         for (int i = 0; i < AX; i++) begin
            acc_min_ff[i] <= s5_ctl.last ? aabbx_pkg::COORD_MAX : mrg_min[i];
            acc_max_ff[i] <= s5_ctl.last ? aabbx_pkg::COORD_MIN : mrg_max[i];
         end
      end
   end

   always_comb begin
      if (last_commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_commit) begin
         rsp_min_ff <= mrg_min;
         rsp_max_ff <= mrg_max;
         rsp_ok_ff  <= mrg_ok;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_min_x = rsp_min_ff[0];
   assign rsp_out_min_y = rsp_min_ff[1];
   assign rsp_out_min_z = rsp_min_ff[2];
   assign rsp_out_max_x = rsp_max_ff[0];
   assign rsp_out_max_y = rsp_max_ff[1];
   assign rsp_out_max_z = rsp_max_ff[2];
   assign rsp_box_valid = rsp_ok_ff;

   assign rsp_ordered = (rsp_out_min_x <= rsp_out_max_x) &&
                        (rsp_out_min_y <= rsp_out_max_y) &&
                        (rsp_out_min_z <= rsp_out_max_z);

   `AABBX_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall && s5_ctl.last))
   `AABBX_ASSERT(a_flag_match, clock, reset, rsp_valid |-> (rsp_box_valid == rsp_ordered))
   `AABBX_ASSERT(a_clear_after_last, clock, reset, last_commit |=> acc_min_ff[0] == aabbx_pkg::COORD_MAX)
   `AABBX_NEVER(a_no_overwrite, clock, reset, rsp_valid && rsp_stall && last_commit)

endmodule

`default_nettype wire

/* rtl/core/aabbx_map.sv */
// ----------------------------------------------------------------------------
// aabbx_map
// Four-stage corner mapping: products, row sums, shift and saturate,
// corner min/max. Points pass through alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabbx_map (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire aabbx_pkg::ctl_type  in_ctl,
   input  wire aabbx_pkg::coord_type in_lo [aabbx_pkg::AXES],
   input  wire aabbx_pkg::coord_type in_hi [aabbx_pkg::AXES],
   input  wire aabbx_pkg::coord_type mat [aabbx_pkg::ROWS][aabbx_pkg::TERMS],
   output aabbx_pkg::ctl_type       out_ctl,
   output aabbx_pkg::coord_type     out_lo [aabbx_pkg::AXES],
   output aabbx_pkg::coord_type     out_hi [aabbx_pkg::AXES]
);

   localparam int AX = aabbx_pkg::AXES;
   localparam int RW = aabbx_pkg::ROWS;
   localparam int NC = aabbx_pkg::CORNERS;

   aabbx_pkg::ctl_type   ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   aabbx_pkg::coord_type pt2_ff [AX];
   aabbx_pkg::coord_type pt3_ff [AX];
   aabbx_pkg::coord_type pt4_ff [AX];

   // products indexed [row][term][lo/hi]
   aabbx_pkg::sum_type   prod_in [RW][AX][2];
   aabbx_pkg::sum_type   prod_ff [RW][AX][2];
   aabbx_pkg::coord_type tr_ff   [RW];
   aabbx_pkg::sum_type   sum_in  [RW][NC];
   aabbx_pkg::sum_type   sum_ff  [RW][NC];
   aabbx_pkg::coord_type crd_in  [RW][NC];
   aabbx_pkg::coord_type crd_ff  [RW][NC];
   aabbx_pkg::coord_type lo5_in  [AX];
   aabbx_pkg::coord_type hi5_in  [AX];
   aabbx_pkg::coord_type lo5_ff  [AX];
   aabbx_pkg::coord_type hi5_ff  [AX];

   always_comb begin
      aabbx_pkg::prod_type p;
      for (int r = 0; r < RW; r++) begin
         for (int j = 0; j < AX; j++) begin
            p = aabbx_pkg::prod_type'(mat[r][j]) * aabbx_pkg::prod_type'(in_lo[j]);
            prod_in[r][j][0] = aabbx_pkg::sum_type'(p);
            p = aabbx_pkg::prod_type'(mat[r][j]) * aabbx_pkg::prod_type'(in_hi[j]);
            prod_in[r][j][1] = aabbx_pkg::sum_type'(p);
         end
      end
   end

   // corner k takes hi on axis j where bit j of k is set
   always_comb begin
      logic [2:0] kb;
      for (int r = 0; r < RW; r++) begin
         for (int k = 0; k < NC; k++) begin
            kb = 3'(k);
            sum_in[r][k] = prod_ff[r][0][kb[0]] + prod_ff[r][1][kb[1]]
                         + prod_ff[r][2][kb[2]]
                         + (aabbx_pkg::sum_type'(tr_ff[r]) <<< aabbx_pkg::FRAC_BITS);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < RW; r++) begin
         for (int k = 0; k < NC; k++) begin
            crd_in[r][k] = aabbx_pkg::sat_coord(sum_ff[r][k]);
         end
      end
   end

   always_comb begin
      aabbx_pkg::coord_type mn4 [4];
      aabbx_pkg::coord_type mx4 [4];
      aabbx_pkg::coord_type mn2 [2];
      aabbx_pkg::coord_type mx2 [2];
      for (int r = 0; r < RW; r++) begin
         for (int i = 0; i < 4; i++) begin
            mn4[i] = aabbx_pkg::min_coord(crd_ff[r][2*i], crd_ff[r][2*i+1]);
            mx4[i] = aabbx_pkg::max_coord(crd_ff[r][2*i], crd_ff[r][2*i+1]);
         end
         for (int i = 0; i < 2; i++) begin
            mn2[i] = aabbx_pkg::min_coord(mn4[2*i], mn4[2*i+1]);
            mx2[i] = aabbx_pkg::max_coord(mx4[2*i], mx4[2*i+1]);
         end
         if (ctl4_ff.point) begin
            lo5_in[r] = pt4_ff[r];
            hi5_in[r] = pt4_ff[r];
         end else begin
            lo5_in[r] = aabbx_pkg::min_coord(mn2[0], mn2[1]);
            hi5_in[r] = aabbx_pkg::max_coord(mx2[0], mx2[1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else if (adv) begin
         ctl2_ff <= in_ctl;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         crd_ff  <= crd_in;
         lo5_ff  <= lo5_in;
         hi5_ff  <= hi5_in;
         pt2_ff  <= in_lo;
         pt3_ff  <= pt2_ff;
         pt4_ff  <= pt3_ff;
         for (int r = 0; r < RW; r++) begin
            tr_ff[r] <= mat[r][aabbx_pkg::TERMS-1];
         end
      end
   end

   assign out_ctl = ctl5_ff;
   assign out_lo  = lo5_ff;
   assign out_hi  = hi5_ff;

endmodule

`default_nettype wire

/* verif/aabb_transform_accumulate_core_tb.sv */
// ----------------------------------------------------------------------------
// aabb_transform_accumulate_core_tb
// Self-checking bench for the bounding box transform core. A queue-fed
// driver offers point, box, matrix-row and spare-opcode transactions in
// random bursts. Each accepted transaction updates a local copy of the box
// and the affine matrix, and every transaction flagged last queues the box
// that the core should return. A monitor compares each returned box field by
// field while the receiver stalls at random, with one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_transform_accumulate_core_tb;

   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_START   = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_CMDS  = 700;

   localparam logic [2:0] OP_SPARE = 3'(aabbx_pkg::OP_ROW2) + 3'd1;
   localparam logic [2:0] OP_TOP   = {3{1'b1}};
   localparam aabbx_pkg::sum_type   SUM_HI = aabbx_pkg::sum_type'(aabbx_pkg::COORD_MAX);
   localparam aabbx_pkg::sum_type   SUM_LO = aabbx_pkg::sum_type'(aabbx_pkg::COORD_MIN);
   localparam aabbx_pkg::coord_type HALF   = aabbx_pkg::COORD_ONE >>> 1;
   localparam aabbx_pkg::coord_type C_MAX  = aabbx_pkg::COORD_MAX;
   localparam aabbx_pkg::coord_type C_MIN  = aabbx_pkg::COORD_MIN;
   localparam aabbx_pkg::coord_type C_ONE  = aabbx_pkg::COORD_ONE;

   typedef struct packed {
      logic [2:0]           opcode;
      aabbx_pkg::coord_type a_x;
      aabbx_pkg::coord_type a_y;
      aabbx_pkg::coord_type a_z;
      aabbx_pkg::coord_type b_x;
      aabbx_pkg::coord_type b_y;
      aabbx_pkg::coord_type b_z;
      logic                 last;
   } bbox_cmd_type;

   typedef struct packed {
      aabbx_pkg::coord_type min_x;
      aabbx_pkg::coord_type min_y;
      aabbx_pkg::coord_type min_z;
      aabbx_pkg::coord_type max_x;
      aabbx_pkg::coord_type max_y;
      aabbx_pkg::coord_type max_z;
      logic                 box_valid;
   } bbox_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_opcode = '0;
   aabbx_pkg::coord_type req_a_x = '0;
   aabbx_pkg::coord_type req_a_y = '0;
   aabbx_pkg::coord_type req_a_z = '0;
   aabbx_pkg::coord_type req_b_x = '0;
   aabbx_pkg::coord_type req_b_y = '0;
   aabbx_pkg::coord_type req_b_z = '0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   aabbx_pkg::coord_type rsp_out_min_x;
   aabbx_pkg::coord_type rsp_out_min_y;
   aabbx_pkg::coord_type rsp_out_min_z;
   aabbx_pkg::coord_type rsp_out_max_x;
   aabbx_pkg::coord_type rsp_out_max_y;
   aabbx_pkg::coord_type rsp_out_max_z;
   logic                 rsp_box_valid;

   aabb_transform_accumulate_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_z       (req_a_z),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_z       (req_b_z),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_min_x (rsp_out_min_x),
      .rsp_out_min_y (rsp_out_min_y),
      .rsp_out_min_z (rsp_out_min_z),
      .rsp_out_max_x (rsp_out_max_x),
      .rsp_out_max_y (rsp_out_max_y),
      .rsp_out_max_z (rsp_out_max_z),
      .rsp_box_valid (rsp_box_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Box and matrix tracking
   // ------------------------------------------------------------------
   aabbx_pkg::coord_type box_lo [aabbx_pkg::AXES];
   aabbx_pkg::coord_type box_hi [aabbx_pkg::AXES];
   aabbx_pkg::coord_type xform  [aabbx_pkg::ROWS*aabbx_pkg::TERMS];
   bbox_cmd_type         pending_cmds [$];
   bbox_result_type      expected_boxes [$];
   int                   error_count = 0;
   int                   cmds_accepted = 0;

   task automatic clear_box();
      int ax;
      for (ax = 0; ax < aabbx_pkg::AXES; ax++) begin
         box_lo[ax] = C_MAX;
         box_hi[ax] = C_MIN;
      end
   endtask

   task automatic merge_point(input aabbx_pkg::coord_type px, input aabbx_pkg::coord_type py,
                              input aabbx_pkg::coord_type pz);
      if (px < box_lo[0]) box_lo[0] = px;
      if (px > box_hi[0]) box_hi[0] = px;
      if (py < box_lo[1]) box_lo[1] = py;
      if (py > box_hi[1]) box_hi[1] = py;
      if (pz < box_lo[2]) box_lo[2] = pz;
      if (pz > box_hi[2]) box_hi[2] = pz;
   endtask

   // one output axis of the affine map: 64-bit wrapping sum, floor shift, clamp
   function automatic aabbx_pkg::coord_type map_axis(input int row,
                                                     input aabbx_pkg::coord_type x,
                                                     input aabbx_pkg::coord_type y,
                                                     input aabbx_pkg::coord_type z);
      aabbx_pkg::sum_type m0, m1, m2, tr, px, py, pz, acc, sh;
      m0 = aabbx_pkg::sum_type'(xform[row*aabbx_pkg::TERMS + 0]);
      m1 = aabbx_pkg::sum_type'(xform[row*aabbx_pkg::TERMS + 1]);
      m2 = aabbx_pkg::sum_type'(xform[row*aabbx_pkg::TERMS + 2]);
      tr = aabbx_pkg::sum_type'(xform[row*aabbx_pkg::TERMS + 3]);
      px = aabbx_pkg::sum_type'(x);
      py = aabbx_pkg::sum_type'(y);
      pz = aabbx_pkg::sum_type'(z);
      acc = m0 * px + m1 * py + m2 * pz + (tr <<< aabbx_pkg::FRAC_BITS);
      sh = acc >>> aabbx_pkg::FRAC_BITS;
      if (sh > SUM_HI) return C_MAX;
      if (sh < SUM_LO) return C_MIN;
      return sh[aabbx_pkg::COORD_WIDTH-1:0];
   endfunction

   task automatic advance_bbox(input bbox_cmd_type c);
      aabbx_pkg::coord_type lo [aabbx_pkg::AXES];
      aabbx_pkg::coord_type hi [aabbx_pkg::AXES];
      aabbx_pkg::coord_type cx, cy, cz;
      logic                 ordered;
      bbox_result_type      res;
      int                   k, ax, row;
      lo[0] = c.a_x;
      lo[1] = c.a_y;
      lo[2] = c.a_z;
      hi[0] = c.b_x;
      hi[1] = c.b_y;
      hi[2] = c.b_z;
      case (c.opcode)
         aabbx_pkg::OP_POINT: begin
            merge_point(lo[0], lo[1], lo[2]);
         end
         aabbx_pkg::OP_BOX: begin
            ordered = 1'b1;
            for (ax = 0; ax < aabbx_pkg::AXES; ax++) begin
               if (lo[ax] > hi[ax]) ordered = 1'b0;
            end
            if (ordered) begin
               for (k = 0; k < aabbx_pkg::CORNERS; k++) begin
                  cx = k[0] ? hi[0] : lo[0];
                  cy = k[1] ? hi[1] : lo[1];
                  cz = k[2] ? hi[2] : lo[2];
                  merge_point(map_axis(0, cx, cy, cz), map_axis(1, cx, cy, cz),
                              map_axis(2, cx, cy, cz));
               end
            end
         end
         aabbx_pkg::OP_ROW0, aabbx_pkg::OP_ROW1, aabbx_pkg::OP_ROW2: begin
            row = int'(c.opcode - 3'(aabbx_pkg::OP_ROW0));
            xform[row*aabbx_pkg::TERMS + 0] = c.a_x;
            xform[row*aabbx_pkg::TERMS + 1] = c.a_y;
            xform[row*aabbx_pkg::TERMS + 2] = c.a_z;
            xform[row*aabbx_pkg::TERMS + 3] = c.b_x;
         end
         default: begin
         end
      endcase
      if (c.last) begin
         res.min_x = box_lo[0];
         res.min_y = box_lo[1];
         res.min_z = box_lo[2];
         res.max_x = box_hi[0];
         res.max_y = box_hi[1];
         res.max_z = box_hi[2];
         res.box_valid = (box_lo[0] <= box_hi[0]) && (box_lo[1] <= box_hi[1]) &&
                         (box_lo[2] <= box_hi[2]);
         expected_boxes.push_back(res);
         clear_box();
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic aabbx_pkg::coord_type rand_coord();
      int unsigned          pick;
      aabbx_pkg::coord_type v;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         v = aabbx_pkg::coord_type'($urandom);
      end else if (pick == 1) begin
         case ($urandom_range(0, 4))
            0: v = C_MAX;
            1: v = C_MIN;
            2: v = '0;
            3: v = '1;
            default: v = C_ONE;
         endcase
      end else begin
         v = aabbx_pkg::coord_type'($urandom_range(0, 32'h0080_0000))
             - aabbx_pkg::coord_type'(32'h0040_0000);
      end
      return v;
   endfunction

   // matrix terms kept mostly within +/-2.0 so that boxes rarely clamp
   function automatic aabbx_pkg::coord_type rand_term();
      if ($urandom_range(0, 7) == 0) return aabbx_pkg::coord_type'($urandom);
      return aabbx_pkg::coord_type'($urandom_range(0, 32'h0004_0000))
             - aabbx_pkg::coord_type'(32'h0002_0000);
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input aabbx_pkg::coord_type ax,
                            input aabbx_pkg::coord_type ay, input aabbx_pkg::coord_type az,
                            input aabbx_pkg::coord_type bx, input aabbx_pkg::coord_type by,
                            input aabbx_pkg::coord_type bz, input logic lst);
      bbox_cmd_type c;
      c.opcode = op;
      c.a_x = ax;
      c.a_y = ay;
      c.a_z = az;
      c.b_x = bx;
      c.b_y = by;
      c.b_z = bz;
      c.last = lst;
      pending_cmds.push_back(c);
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input aabbx_pkg::coord_type got,
                              input aabbx_pkg::coord_type want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: bursts of transactions separated by random gaps
   // ------------------------------------------------------------------
   bbox_cmd_type cur_cmd;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_bbox(cur_cmd);
            cmds_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               cur_cmd = pending_cmds.pop_front();
               req_opcode <= cur_cmd.opcode;
               req_a_x    <= cur_cmd.a_x;
               req_a_y    <= cur_cmd.a_y;
               req_a_z    <= cur_cmd.a_z;
               req_b_x    <= cur_cmd.b_x;
               req_b_y    <= cur_cmd.b_y;
               req_b_z    <= cur_cmd.b_z;
               req_last   <= cur_cmd.last;
               req_valid  <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall pattern and long hold-off
   // ------------------------------------------------------------------
   int   run_cycles = 0;
   logic hold_active = 1'b0;
   int   stall_mode = 0;
   int   mode_left = 0;
   logic stall_bit;

   always @(posedge clock) begin
      if (reset) begin
         run_cycles  <= 0;
         hold_active <= 1'b0;
      end else begin
         run_cycles  <= run_cycles + 1;
         hold_active <= (run_cycles >= HOLD_START) && (run_cycles < HOLD_START + HOLD_CYCLES);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: stall_bit = 1'b0;
            1: stall_bit = ($urandom_range(0, 3) == 0);
            2: stall_bit = ($urandom_range(0, 1) == 1);
            default: stall_bit = ($urandom_range(0, 3) != 0);
         endcase
         rsp_stall <= hold_active || stall_bit;
      end
   end

   // ------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------
   bbox_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_boxes.size() == 0) begin
            report_mismatch("result transaction with no box expected");
         end else begin
            want = expected_boxes.pop_front();
            check_field("min_x", rsp_out_min_x, want.min_x);
            check_field("min_y", rsp_out_min_y, want.min_y);
            check_field("min_z", rsp_out_min_z, want.min_z);
            check_field("max_x", rsp_out_max_x, want.max_x);
            check_field("max_y", rsp_out_max_y, want.max_y);
            check_field("max_z", rsp_out_max_z, want.max_z);
            check_field("box_valid", aabbx_pkg::coord_type'(rsp_box_valid),
                        aabbx_pkg::coord_type'(want.box_valid));
         end
      end
   end

   // watchdog: consecutive cycles with no transaction on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      bbox_cmd_type c;
      int           n, ax, total_cmds;
      int unsigned  pick;
      for (ax = 0; ax < aabbx_pkg::ROWS*aabbx_pkg::TERMS; ax++) begin
         xform[ax] = '0;
      end
      for (ax = 0; ax < aabbx_pkg::ROWS; ax++) begin
         xform[ax*aabbx_pkg::TERMS + ax] = C_ONE;
      end
      clear_box();

      // empty box out of reset, through a spare opcode
      queue_cmd(OP_SPARE, C_MAX, C_MIN, '1, '0, C_MAX, C_MIN, 1'b1);
      queue_cmd(aabbx_pkg::OP_POINT, C_MAX, C_MIN, '0, '1, C_MAX, C_MIN, 1'b0);
      queue_cmd(aabbx_pkg::OP_POINT, C_MIN, C_MAX, '1, C_MAX, '0, '1, 1'b1);
      // identity matrix out of reset
      queue_cmd(aabbx_pkg::OP_BOX, -C_ONE, -2 * C_ONE, -3 * C_ONE,
                C_ONE, 2 * C_ONE, 3 * C_ONE, 1'b0);
      queue_cmd(aabbx_pkg::OP_BOX, '0, '0, C_ONE, '0, '0, '0, 1'b1);
      // disordered box on its own leaves the box empty
      queue_cmd(aabbx_pkg::OP_BOX, C_ONE, '0, '0, '0, '0, '0, 1'b1);
      // extreme matrix: sums wrap before the shift
      queue_cmd(aabbx_pkg::OP_ROW0, C_MAX, C_MAX, C_MAX, C_MAX, '1, '1, 1'b0);
      queue_cmd(aabbx_pkg::OP_ROW1, C_MIN, C_MIN, C_MIN, C_MIN, '0, '0, 1'b0);
      queue_cmd(aabbx_pkg::OP_ROW2, C_MAX, C_MIN, '0, '1, C_MIN, C_MAX, 1'b0);
      queue_cmd(aabbx_pkg::OP_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
      queue_cmd(OP_SPARE + 3'd1, '1, '1, '1, '1, '1, '1, 1'b0);
      queue_cmd(OP_SPARE + 3'd2, '0, '0, '0, '0, '0, '0, 1'b1);
      queue_cmd(aabbx_pkg::OP_ROW0, C_ONE, '0, '0, '0, '0, '0, 1'b0);
      queue_cmd(aabbx_pkg::OP_ROW1, '0, C_ONE, '0, '0, '0, '0, 1'b0);
      queue_cmd(aabbx_pkg::OP_ROW2, '0, '0, C_ONE, '0, '0, '0, 1'b0);
      queue_cmd(aabbx_pkg::OP_BOX, 7 * C_ONE, -5, 3, 7 * C_ONE, -5, 3, 1'b1);
      // half scale with an offset: negative odd values floor downwards
      queue_cmd(aabbx_pkg::OP_ROW0, HALF, '0, '0, -3, '0, '0, 1'b0);
      queue_cmd(aabbx_pkg::OP_BOX, -1, -3, '0, 1, 5, 7, 1'b1);
      queue_cmd(aabbx_pkg::OP_ROW0, C_ONE, '0, '0, '0, '0, '0, 1'b0);

      for (n = 0; n < RANDOM_CMDS; n++) begin
         pick = $urandom_range(0, 99);
         c.last = ($urandom_range(0, 7) == 0) || (n == RANDOM_CMDS - 1);
         c.a_x = rand_coord();
         c.a_y = rand_coord();
         c.a_z = rand_coord();
         c.b_x = rand_coord();
         c.b_y = rand_coord();
         c.b_z = rand_coord();
         if (pick < 40) begin
            c.opcode = aabbx_pkg::OP_POINT;
         end else if (pick < 75) begin
            c.opcode = aabbx_pkg::OP_BOX;
            // mostly well-ordered boxes; the rest keep their random max corner
            if ($urandom_range(0, 9) != 0) begin
               c.b_x = c.a_x + aabbx_pkg::coord_type'($urandom_range(0, 32'h0020_0000));
               c.b_y = c.a_y + aabbx_pkg::coord_type'($urandom_range(0, 32'h0020_0000));
               c.b_z = c.a_z + aabbx_pkg::coord_type'($urandom_range(0, 32'h0020_0000));
            end
         end else if (pick < 92) begin
            c.opcode = 3'(aabbx_pkg::OP_ROW0) + 3'($urandom_range(0, 2));
            c.a_x = rand_term();
            c.a_y = rand_term();
            c.a_z = rand_term();
            c.b_x = rand_term();
         end else begin
            c.opcode = 3'($urandom_range(OP_SPARE, OP_TOP));
         end
         pending_cmds.push_back(c);
      end
      total_cmds = pending_cmds.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (cmds_accepted < total_cmds || expected_boxes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/aabbx_pkg.sv
rtl/core/aabbx_map.sv
rtl/core/aabb_transform_accumulate_core.sv
verif/aabb_transform_accumulate_core_tb.sv
